FILE: design/fxq_pkg.sv
`timescale 1ns / 1ps
package fxq_pkg;

    // Width of the data ports, fixed by the interface.
    localparam int IO_W = 32;
    localparam int OP_W = 5;

    // Default number format: Q24.8 in a 32-bit word.
    localparam int DEF_WORD_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 8;

    // Quotient bits resolved in each divider stage.
    localparam int DIV_STEP = 4;

    // IEEE single layout.
    localparam int FLT_MANT_W = 23;
    localparam int FLT_BIAS   = 127;

    typedef enum logic [OP_W-1:0] {
        OP_ADD        = 5'd0,
        OP_SUB        = 5'd1,
        OP_MUL        = 5'd2,
        OP_DIV        = 5'd3,
        OP_GT         = 5'd4,
        OP_LT         = 5'd5,
        OP_GE         = 5'd6,
        OP_LE         = 5'd7,
        OP_EQ         = 5'd8,
        OP_NE         = 5'd9,
        OP_MIN        = 5'd10,
        OP_MAX        = 5'd11,
        OP_INC        = 5'd12,
        OP_DEC        = 5'd13,
        OP_FROM_INT   = 5'd14,
        OP_TO_INT     = 5'd15,
        OP_FROM_FLOAT = 5'd16,
        OP_TO_FLOAT   = 5'd17
    } op_t;

endpackage

FILE: design/fixed_point_q24_8_alu.sv
`timescale 1ns / 1ps
// Signed fixed-point arithmetic unit, Q24.8 by default.
//
// The input channel (in_valid / in_ready) carries one transaction per item: an
// operation code and two raw operands. The output channel (out_valid /
// out_ready) returns one transaction per item with the result word, the
// comparison outcome and the divide-by-zero flag, strictly in input order.
//
// The datapath is a single linear pipeline: an input register, a decode stage
// that does the adds, compares, the multiply and the conversion front ends, a
// chain of divider stages that each resolve DIV_STEP quotient bits (the
// conversion back ends and the product shift share the first of them), and an
// output register. Every operation passes all stages. There are N divider
// stages, where N is ceil((WORD_WIDTH + FRAC_BITS) / DIV_STEP). The depth of
// the restoring divider, whose dividend is 40 bits wide for Q24.8, sets the
// depth of the pipeline.
//
// Throughput is one transaction per cycle while results are taken. While the
// output register is empty the pipeline keeps moving and accepting, even with
// out_ready low. Once it holds a result that the receiver does not take, every
// stage freezes in place and in_ready drops, so nothing is lost or repeated.
//
// Reset clears all valid bits; the payload registers are not reset.
module fixed_point_q24_8_alu #(
    parameter int WORD_WIDTH = fxq_pkg::DEF_WORD_WIDTH,
    parameter int FRAC_BITS  = fxq_pkg::DEF_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fxq_pkg::OP_W-1:0]            op,
    input  logic signed [fxq_pkg::IO_W-1:0]     operand_a,
    input  logic signed [fxq_pkg::IO_W-1:0]     operand_b,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [fxq_pkg::IO_W-1:0]     result_value,
    output logic                                compare_true,
    output logic                                divide_by_zero
);
    import fxq_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int D  = W + F;
    localparam int N  = (D + DIV_STEP - 1) / DIV_STEP;
    localparam int DP = N * DIV_STEP;
    localparam int PW = $clog2(W);

    // One enable moves every stage; a full output register that is not being
    // taken holds the whole pipeline.
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Input register.
    logic             s1_valid_reg;
    op_t              s1_op_reg;
    logic [IO_W-1:0]  s1_a_reg;
    logic [IO_W-1:0]  s1_b_reg;

    // Decode stage registers.
    logic                   s2_valid_reg;
    op_t                    s2_op_reg;
    logic signed [IO_W-1:0] s2_res_reg;
    logic                   s2_cmp_reg;
    logic                   s2_dz_reg;
    logic signed [2*W-1:0]  s2_prod_reg;
    logic                   s2_fneg_reg;
    logic                   s2_fnan_reg;
    logic                   s2_finf_reg;
    logic [23:0]            s2_fm_reg;
    logic signed [9:0]      s2_fsh_reg;
    logic                   s2_xsign_reg;
    logic [W-1:0]           s2_xmag_reg;
    logic [PW-1:0]          s2_xp_reg;
    logic [DP-1:0]          s2_num_reg;
    logic [W-1:0]           s2_dvs_reg;
    logic                   s2_neg_reg;

    logic signed [IO_W-1:0] s2_resv_next;
    logic                   s2_cmp_next;
    logic                   s2_dz_next;
    logic signed [2*W-1:0]  s2_prod_next;
    logic                   s2_fneg_next;
    logic                   s2_fnan_next;
    logic                   s2_finf_next;
    logic [23:0]            s2_fm_next;
    logic signed [9:0]      s2_fsh_next;
    logic                   s2_xsign_next;
    logic [W-1:0]           s2_xmag_next;
    logic [PW-1:0]          s2_xp_next;
    logic [DP-1:0]          s2_num_next;
    logic [W-1:0]           s2_dvs_next;
    logic                   s2_neg_next;

    always_comb
    begin
        logic signed [W-1:0] a_w;
        logic signed [W-1:0] b_w;
        logic signed [W-1:0] r_w;
        logic [W-1:0]        abs_a;
        logic [W-1:0]        abs_b;
        logic [7:0]          ex;
        logic [22:0]         frac;
        logic [8:0]          ex_eff;

        a_w    = signed'(s1_a_reg[W-1:0]);
        b_w    = signed'(s1_b_reg[W-1:0]);
        abs_a  = a_w[W-1] ? W'(-a_w) : W'(a_w);
        abs_b  = b_w[W-1] ? W'(-b_w) : W'(b_w);
        r_w    = '0;
        s2_cmp_next = 1'b0;

        unique case (s1_op_reg)
            OP_ADD:      r_w = a_w + b_w;
            OP_SUB:      r_w = a_w - b_w;
            OP_MIN:      r_w = (a_w > b_w) ? b_w : a_w;
            OP_MAX:      r_w = (a_w < b_w) ? b_w : a_w;
            OP_INC:      r_w = a_w + W'(1);
            OP_DEC:      r_w = a_w - W'(1);
            OP_FROM_INT: r_w = a_w <<< F;
            OP_TO_INT:   r_w = a_w >>> F;
            OP_GT:       s2_cmp_next = a_w > b_w;
            OP_LT:       s2_cmp_next = a_w < b_w;
            OP_GE:       s2_cmp_next = a_w >= b_w;
            OP_LE:       s2_cmp_next = a_w <= b_w;
            OP_EQ:       s2_cmp_next = a_w == b_w;
            OP_NE:       s2_cmp_next = a_w != b_w;
            default:     r_w = '0;
        endcase
        s2_resv_next = IO_W'(r_w);

        s2_dz_next   = (s1_op_reg == OP_DIV) && (b_w == '0);
        s2_prod_next = (2*W)'(a_w) * (2*W)'(b_w);

        // Float to fixed front end: unpack and find the scaling shift.
        ex            = s1_a_reg[30:23];
        frac          = s1_a_reg[22:0];
        s2_fneg_next  = s1_a_reg[31];
        s2_fnan_next  = (ex == 8'hFF) && (frac != '0);
        s2_finf_next  = (ex == 8'hFF) && (frac == '0);
        s2_fm_next    = (ex == 8'd0) ? {1'b0, frac} : {1'b1, frac};
        ex_eff        = (ex == 8'd0) ? 9'd1 : {1'b0, ex};
        s2_fsh_next   = signed'({1'b0, ex_eff}) - 10'sd150 + 10'(F);

        // Fixed to float front end: magnitude and leading one position.
        s2_xsign_next = a_w[W-1];
        s2_xmag_next  = abs_a;
        s2_xp_next    = '0;
        for (int i = 0; i < W; i++)
        begin
            if (abs_a[i])
            begin
                s2_xp_next = PW'(i);
            end
        end

        // Divider operands: magnitudes, quotient sign applied at the end.
        s2_num_next = DP'({abs_a, {F{1'b0}}});
        s2_dvs_next = abs_b;
        s2_neg_next = a_w[W-1] ^ b_w[W-1];
    end

    // Divider stages.
    logic                   d_valid_reg [N];
    op_t                    d_op_reg    [N];
    logic signed [IO_W-1:0] d_res_reg   [N];
    logic                   d_cmp_reg   [N];
    logic                   d_dz_reg    [N];
    logic                   d_neg_reg   [N];
    logic [DP-1:0]          d_num_reg   [N];
    logic [W-1:0]           d_rem_reg   [N];
    logic [W-1:0]           d_dvs_reg   [N];

    logic signed [IO_W-1:0] d_res_next  [N];
    logic [DP-1:0]          d_num_next  [N];
    logic [W-1:0]           d_rem_next  [N];
    logic [DP-1:0]          d_num_src   [N];
    logic [W-1:0]           d_rem_src   [N];
    logic [W-1:0]           d_dvs_src   [N];

    // Back ends of the multiply and the conversions, ahead of the first
    // divider stage.
    logic signed [IO_W-1:0] side_res;

    always_comb
    begin
        logic signed [W-1:0] mul_w;
        logic signed [W-1:0] fx_w;
        logic [32:0]         flim;
        logic [56:0]         fmag;
        int                  sh;
        logic [24:0]         mant;
        logic [31:0]         mag32;
        logic [31:0]         remv;
        logic [31:0]         half;
        logic [5:0]          pe;
        logic [8:0]          expo;
        logic [IO_W-1:0]     flt;

        mul_w = W'(s2_prod_reg >>> F);

        flim = s2_fneg_reg ? (33'(1) << (W - 1)) : ((33'(1) << (W - 1)) - 33'(1));
        sh   = int'(s2_fsh_reg);
        fmag = '0;
        if (s2_fnan_reg)
        begin
            fmag = '0;
        end
        else if (s2_finf_reg)
        begin
            fmag = 57'(flim);
        end
        else if (s2_fm_reg == '0)
        begin
            fmag = '0;
        end
        else if (sh >= 0)
        begin
            fmag = (sh > 32) ? 57'(flim) + 57'(1) : 57'(s2_fm_reg) << sh;
        end
        else if (-sh <= 25)
        begin
            fmag = (57'(s2_fm_reg) + (57'(1) << (-sh - 1))) >> (-sh);
        end
        if (fmag > 57'(flim))
        begin
            fmag = 57'(flim);
        end
        fx_w = s2_fneg_reg ? -signed'(W'(fmag)) : signed'(W'(fmag));

        mag32 = 32'(s2_xmag_reg);
        pe    = 6'(s2_xp_reg);
        remv  = '0;
        half  = '0;
        if (pe <= 6'(FLT_MANT_W))
        begin
            mant = 25'(mag32 << (6'(FLT_MANT_W) - pe));
        end
        else
        begin
            mant = 25'(mag32 >> (pe - 6'(FLT_MANT_W)));
            remv = mag32 & ((32'(1) << (pe - 6'(FLT_MANT_W))) - 32'(1));
            half = 32'(1) << (pe - 6'(FLT_MANT_W) - 6'(1));
            if ((remv > half) || ((remv == half) && mant[0]))
            begin
                mant = mant + 25'(1);
            end
            if (mant[24])
            begin
                mant = mant >> 1;
                pe   = pe + 6'(1);
            end
        end
        expo = 9'(pe) + 9'(FLT_BIAS) - 9'(F);
        flt  = (s2_xmag_reg == '0) ? '0 : {s2_xsign_reg, expo[7:0], mant[22:0]};

        case (s2_op_reg)
            OP_MUL:        side_res = IO_W'(mul_w);
            OP_FROM_FLOAT: side_res = IO_W'(fx_w);
            OP_TO_FLOAT:   side_res = signed'(flt);
            default:       side_res = s2_res_reg;
        endcase
    end

    always_comb
    begin
        logic [W:0]    r2;
        logic [DP-1:0] num;

        d_num_src[0] = s2_num_reg;
        d_rem_src[0] = '0;
        d_dvs_src[0] = s2_dvs_reg;
        d_res_next[0] = side_res;
        for (int st = 1; st < N; st++)
        begin
            d_num_src[st]  = d_num_reg[st-1];
            d_rem_src[st]  = d_rem_reg[st-1];
            d_dvs_src[st]  = d_dvs_reg[st-1];
            d_res_next[st] = d_res_reg[st-1];
        end

        // Restoring division, DIV_STEP quotient bits per stage; quotient bits
        // shift into the low end of the dividend register.
        for (int st = 0; st < N; st++)
        begin
            num = d_num_src[st];
            r2  = {1'b0, d_rem_src[st]};
            for (int k = 0; k < DIV_STEP; k++)
            begin
                r2  = {r2[W-1:0], num[DP-1]};
                num = num << 1;
                if (r2 >= {1'b0, d_dvs_src[st]})
                begin
                    r2     = r2 - {1'b0, d_dvs_src[st]};
                    num[0] = 1'b1;
                end
            end
            d_num_next[st] = num;
            d_rem_next[st] = r2[W-1:0];
        end
    end

    // Output register.
    logic                   out_valid_reg;
    logic signed [IO_W-1:0] result_value_reg;
    logic                   compare_true_reg;
    logic                   divide_by_zero_reg;
    logic signed [IO_W-1:0] result_value_next;

    always_comb
    begin
        logic [W-1:0] q_w;

        q_w = W'(d_num_reg[N-1]);
        if (d_neg_reg[N-1])
        begin
            q_w = -q_w;
        end
        if ((d_op_reg[N-1] == OP_DIV) && !d_dz_reg[N-1])
        begin
            result_value_next = IO_W'(signed'(q_w));
        end
        else
        begin
            result_value_next = d_res_reg[N-1];
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int st = 0; st < N; st++)
            begin
                d_valid_reg[st] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_valid_reg   <= in_valid;
            s2_valid_reg   <= s1_valid_reg;
            d_valid_reg[0] <= s2_valid_reg;
            for (int st = 1; st < N; st++)
            begin
                d_valid_reg[st] <= d_valid_reg[st-1];
            end
            out_valid_reg <= d_valid_reg[N-1];
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg <= op_t'(op);
            s1_a_reg  <= operand_a;
            s1_b_reg  <= operand_b;

            s2_op_reg    <= s1_op_reg;
            s2_res_reg   <= s2_resv_next;
            s2_cmp_reg   <= s2_cmp_next;
            s2_dz_reg    <= s2_dz_next;
            s2_prod_reg  <= s2_prod_next;
            s2_fneg_reg  <= s2_fneg_next;
            s2_fnan_reg  <= s2_fnan_next;
            s2_finf_reg  <= s2_finf_next;
            s2_fm_reg    <= s2_fm_next;
            s2_fsh_reg   <= s2_fsh_next;
            s2_xsign_reg <= s2_xsign_next;
            s2_xmag_reg  <= s2_xmag_next;
            s2_xp_reg    <= s2_xp_next;
            s2_num_reg   <= s2_num_next;
            s2_dvs_reg   <= s2_dvs_next;
            s2_neg_reg   <= s2_neg_next;

            d_op_reg[0]  <= s2_op_reg;
            d_cmp_reg[0] <= s2_cmp_reg;
            d_dz_reg[0]  <= s2_dz_reg;
            d_neg_reg[0] <= s2_neg_reg;
            for (int st = 1; st < N; st++)
            begin
                d_op_reg[st]  <= d_op_reg[st-1];
                d_cmp_reg[st] <= d_cmp_reg[st-1];
                d_dz_reg[st]  <= d_dz_reg[st-1];
                d_neg_reg[st] <= d_neg_reg[st-1];
            end
            for (int st = 0; st < N; st++)
            begin
                d_res_reg[st] <= d_res_next[st];
                d_num_reg[st] <= d_num_next[st];
                d_rem_reg[st] <= d_rem_next[st];
                d_dvs_reg[st] <= d_dvs_src[st];
            end

            result_value_reg   <= result_value_next;
            compare_true_reg   <= d_cmp_reg[N-1];
            divide_by_zero_reg <= d_dz_reg[N-1];
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_value   = result_value_reg;
    assign compare_true   = compare_true_reg;
    assign divide_by_zero = divide_by_zero_reg;

endmodule

FILE: design/fxq_checker.sv
`timescale 1ns / 1ps
module fxq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic signed [fxq_pkg::IO_W-1:0] result_value,
    input logic                            compare_true,
    input logic                            divide_by_zero
);
    import fxq_pkg::*;

    // A held result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value)
        && $stable(compare_true) && $stable(divide_by_zero))
        else $error("output changed while stalled");

    // An empty output register never blocks the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    // A comparison gives no result word.
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && compare_true |-> result_value == '0 && !divide_by_zero)
        else $error("comparison with nonzero result word");

    // A zero divisor gives a zero result.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> result_value == '0)
        else $error("divide by zero with nonzero result");

endmodule

bind fixed_point_q24_8_alu fxq_checker u_fxq_checker (.*);

FILE: test/fixed_point_q24_8_alu_checker.sv
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_checker
    import fxq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [OP_W-1:0]        op,
    input  logic signed [IO_W-1:0] operand_a,
    input  logic signed [IO_W-1:0] operand_b,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic signed [IO_W-1:0] result_value,
    input  logic                   compare_true,
    input  logic                   divide_by_zero,
    output int                     mismatch_count,
    output int                     pending_count
);

    typedef struct packed {
        logic [31:0] value;
        logic        cmp;
        logic        dz;
    } alu_result_t;

    alu_result_t expected_results[$];

    // Arithmetic shift right of a 64-bit value, rounding toward minus infinity.
    function automatic longint floor_shift(longint x);
        return x >>> DEF_FRAC_BITS;
    endfunction

    function automatic logic [31:0] float_bits_to_fixed(logic [31:0] bits);
        logic        neg;
        int          ex;
        longint      mant;
        longint      mag;
        longint      lim;
        int          sh;
        neg  = bits[31];
        ex   = int'(bits[30:23]);
        mant = longint'(bits[22:0]);
        lim  = neg ? 64'sh8000_0000 : 64'sh7FFF_FFFF;
        if (ex == 255) begin
            if (mant != 0)
                return 32'd0;
            mag = lim;
        end
        else begin
            if (ex == 0)
                ex = 1;
            else
                mant = mant | (64'sd1 << 23);
            if (mant == 0)
                return 32'd0;
            sh = ex - 150 + DEF_FRAC_BITS;
            if (sh >= 0)
                mag = (sh > 32) ? lim + 1 : (mant << sh);
            else if (-sh > 25)
                mag = 0;
            else
                mag = (mant + (64'sd1 << (-sh - 1))) >> (-sh);
            if (mag > lim)
                mag = lim;
        end
        mag = neg ? -mag : mag;
        return mag[31:0];
    endfunction

    function automatic logic [31:0] fixed_to_float_bits(longint v);
        logic        sign;
        longint      mag;
        longint      mant;
        longint      rem;
        longint      half;
        int          p;
        int          r;
        logic [31:0] bits;
        if (v == 0)
            return 32'd0;
        sign = v < 0;
        mag  = sign ? -v : v;
        p = 0;
        while ((mag >> (p + 1)) != 0)
            p++;
        if (p <= 23) begin
            mant = mag << (23 - p);
        end
        else begin
            r    = p - 23;
            mant = mag >> r;
            rem  = mag & ((64'sd1 << r) - 1);
            half = 64'sd1 << (r - 1);
            if (rem > half || (rem == half && mant[0]))
                mant++;
            if (mant == (64'sd1 << 24)) begin
                mant = mant >> 1;
                p++;
            end
        end
        bits[31]    = sign;
        bits[30:23] = 8'(p - DEF_FRAC_BITS + FLT_BIAS);
        bits[22:0]  = mant[22:0];
        return bits;
    endfunction

    function automatic alu_result_t compute_alu(logic [OP_W-1:0] code,
                                                logic [31:0] a_bits,
                                                logic [31:0] b_bits);
        alu_result_t res;
        longint      a;
        longint      b;
        longint      w;
        a = longint'($signed(a_bits));
        b = longint'($signed(b_bits));
        w = 0;
        res = '0;
        case (code)
            OP_ADD:      w = a + b;
            OP_SUB:      w = a - b;
            OP_MUL:      w = floor_shift(a * b);
            OP_DIV:
                if (b == 0)
                    res.dz = 1'b1;
                else
                    w = (a * (64'sd1 << DEF_FRAC_BITS)) / b;
            OP_GT:       res.cmp = a > b;
            OP_LT:       res.cmp = a < b;
            OP_GE:       res.cmp = a >= b;
            OP_LE:       res.cmp = a <= b;
            OP_EQ:       res.cmp = a == b;
            OP_NE:       res.cmp = a != b;
            OP_MIN:      w = (a > b) ? b : a;
            OP_MAX:      w = (a < b) ? b : a;
            OP_INC:      w = a + 1;
            OP_DEC:      w = a - 1;
            OP_FROM_INT: w = a * (64'sd1 << DEF_FRAC_BITS);
            OP_TO_INT:   w = floor_shift(a);
            default:     w = 0;
        endcase
        res.value = w[31:0];
        if (code == OP_FROM_FLOAT)
            res.value = float_bits_to_fixed(a_bits);
        else if (code == OP_TO_FLOAT)
            res.value = fixed_to_float_bits(a);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk) begin
        alu_result_t want;
        if (!rst_n) begin
            expected_results.delete();
            mismatch_count = 0;
        end
        else begin
            if (in_valid && in_ready)
                expected_results.push_back(compute_alu(op, operand_a, operand_b));
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", result_value, 32'd0);
                end
                else begin
                    want = expected_results.pop_front();
                    if (result_value !== want.value)
                        report_mismatch("result_value", result_value, want.value);
                    if (compare_true !== want.cmp)
                        report_mismatch("compare_true", 32'(compare_true), 32'(want.cmp));
                    if (divide_by_zero !== want.dz)
                        report_mismatch("divide_by_zero", 32'(divide_by_zero),
                                        32'(want.dz));
                end
            end
        end
        pending_count = expected_results.size();
    end

endmodule

FILE: test/fixed_point_q24_8_alu_test.sv
`timescale 1ns / 1ps
// Top of the testbench for the Q24.8 arithmetic unit. It makes the stimulus,
// runs the receiver's stall pattern and gives the verdict; the checker beside
// the block predicts every result and counts mismatches.
module fixed_point_q24_8_alu_test;
    import fxq_pkg::*;

    localparam int RANDOM_ITEMS = 1830;
    localparam int IDLE_LIMIT   = 5000;
    // Drain generously past the pipeline depth for Q24.8.
    localparam int DRAIN_CYCLES = 40;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [OP_W-1:0]        op;
    logic signed [IO_W-1:0] operand_a;
    logic signed [IO_W-1:0] operand_b;
    logic                   out_valid;
    logic                   out_ready;
    logic signed [IO_W-1:0] result_value;
    logic                   compare_true;
    logic                   divide_by_zero;
    int                     mismatch_count;
    int                     pending_count;
    int                     idle_cycles;

    fixed_point_q24_8_alu i_dut (.*);

    fixed_point_q24_8_alu_checker i_checker (.*);

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Operand values that sit at the edges of the number range, or small values near zero.
    function automatic logic [31:0] edge_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0100;
            5: return 32'hFFFF_FF00;
            6: return 32'h0000_0001;
            default: return $urandom_range(0, 4095) - 2048;
        endcase
    endfunction

    // A float whose exponent lands near the fixed-point window, so that
    // rounding and saturation both get exercised; sometimes an exponent of all ones or zero, sometimes raw bits.
    function automatic logic [31:0] float_operand();
        logic [31:0] bits;
        bits = $urandom;
        if ($urandom_range(0, 3) != 0)
            bits[30:23] = 8'($urandom_range(100, 165));
        else if ($urandom_range(0, 1) != 0)
            bits[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return bits;
    endfunction

    // Offer one transaction and hold it until the block takes it.
    task automatic send_op(logic [OP_W-1:0] code, logic [31:0] a, logic [31:0] b);
        in_valid  <= 1'b1;
        op        <= code;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random();
        logic [OP_W-1:0] code;
        logic [31:0]     a;
        logic [31:0]     b;
        // Mostly valid codes, now and then an unused one.
        code = ($urandom_range(0, 31) == 0) ? OP_W'($urandom_range(18, 31))
                                            : OP_W'($urandom_range(0, 17));
        a = $urandom_range(0, 2) == 0 ? edge_operand() : $urandom;
        b = $urandom_range(0, 2) == 0 ? edge_operand() : $urandom;
        if (code == OP_FROM_FLOAT)
            a = float_operand();
        if (code == OP_DIV && $urandom_range(0, 7) == 0)
            b = 32'd0;
        if (code >= OP_GT && code <= OP_MAX && $urandom_range(0, 3) == 0)
            b = a;
        send_op(code, a, b);
    endtask

    // The receiver accepts freely at first, then once holds off for a long
    // stretch so the pipeline fills and in_ready drops, then stalls on its
    // own random pattern.
    initial
    begin
        int hold;
        out_ready <= 1'b0;
        @(posedge rst_n);
        repeat (2) @(posedge clk);
        out_ready <= 1'b1;
        repeat (298) @(posedge clk);
        out_ready <= 1'b0;
        for (hold = 0; hold < 60; hold++)
            @(posedge clk);
        forever
        begin
            case ($urandom_range(0, 3))
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 3) != 0);
            endcase
            @(posedge clk);
        end
    end

    // Watchdog: a run with no accepted transaction and no taken result for too long is a failure.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int n;
        int burst;
        int gap;
        int k;
        logic [OP_W-1:0] code;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = '0;
        operand_a   = '0;
        operand_b   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: every operation on extreme operands, then the
        // special cases of divide, float conversion and unused codes.
        for (k = 0; k <= OP_TO_FLOAT; k++)
        begin
            code = OP_W'(k);
            send_op(code, 32'h8000_0000, 32'h7FFF_FFFF);
        end
        send_op(OP_DIV, 32'h0000_0100, 32'd0);
        send_op(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(OP_FROM_FLOAT, 32'h7FC0_0000, 32'd0);
        send_op(OP_FROM_FLOAT, 32'hFF80_0000, 32'd0);
        send_op(OP_FROM_FLOAT, 32'h3F40_0000, 32'd0);
        send_op(OP_FROM_FLOAT, 32'h0000_0001, 32'd0);
        send_op(OP_TO_FLOAT, 32'h0000_0000, 32'd0);
        send_op(OP_TO_FLOAT, 32'h7FFF_FFFF, 32'd0);
        send_op(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random part in bursts. Bursts span the receiver's long hold, so
        // the sender keeps offering while the block backs up.
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst && n < RANDOM_ITEMS; k++)
            begin
                send_random();
                n++;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: fixed_point_q24_8_alu.f
design/fxq_pkg.sv
design/fixed_point_q24_8_alu.sv
design/fxq_checker.sv
test/fixed_point_q24_8_alu_checker.sv
test/fixed_point_q24_8_alu_test.sv
